// File: src/busiest_queue_select_unit_macros.svh
// ----------------------------------------------------------------------------
// Busiest queue select unit assertion macros
// Shared concurrent assertion wrappers for the busiest queue select RTL.
// ----------------------------------------------------------------------------
`ifndef BUSIEST_QUEUE_SELECT_UNIT_MACROS_SVH
`define BUSIEST_QUEUE_SELECT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define BQS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BQS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BQS_ASSERT(name, clk, rst, prop, msg)
`define BQS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/bqs_pkg.sv
// ----------------------------------------------------------------------------
// Busiest queue select package
// Field widths, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package bqs_pkg;

   localparam int unsigned CLASS_BITS     = 2;
   localparam int unsigned CAP_BITS       = 11;
   localparam int unsigned COUNT_BITS     = 16;
   localparam int unsigned LIMIT_BITS     = 32;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLASS_LIMIT     = 3'd0,
      CSR_MISFIT_MODE     = 3'd1,
      CSR_ASYM_CAPACITY   = 3'd2,
      CSR_DEST_CAPACITY   = 3'd3,
      CSR_IMBALANCE_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CLASS_BITS-1:0] class_limit;
      logic                  misfit_mode;
      logic                  asym_capacity;
      logic [CAP_BITS-1:0]   dest_capacity;
      logic [LIMIT_BITS-1:0] imbalance_limit;
   } cfg_type;

   localparam logic [CLASS_BITS-1:0] CLASS_LIMIT_RESET   = 2'd2;
   localparam logic [CAP_BITS-1:0]   DEST_CAPACITY_RESET = 11'd1024;
   localparam logic [CAP_BITS-1:0]   BEST_CAPACITY_RESET = 11'd1;
   localparam logic [COUNT_BITS-1:0] LONE_TASK_COUNT     = 16'd1;

endpackage

`default_nettype wire

// File: src/bqs_req_if.sv
// ----------------------------------------------------------------------------
// Queue descriptor channel
// Valid/ready channel carrying one run queue descriptor per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqs_req_if
   import bqs_pkg::*;
#(
   parameter int unsigned INDEX_BITS = 8,
   parameter int unsigned LOAD_BITS  = 32
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] queue_index;
   logic [CLASS_BITS-1:0] queue_class;
   logic [CAP_BITS-1:0]   queue_capacity;
   logic [LOAD_BITS-1:0]  queue_load;
   logic [COUNT_BITS-1:0] running_count;
   logic [LOAD_BITS-1:0]  misfit_load;
   logic                  capacity_reduced;
   logic                  last_queue;

   modport source (
      output valid, queue_index, queue_class, queue_capacity, queue_load,
             running_count, misfit_load, capacity_reduced, last_queue,
      input  ready
   );

   modport sink (
      input  valid, queue_index, queue_class, queue_capacity, queue_load,
             running_count, misfit_load, capacity_reduced, last_queue,
      output ready
   );
endinterface

`default_nettype wire

// File: src/bqs_rsp_if.sv
// ----------------------------------------------------------------------------
// Selection result channel
// Valid/ready channel carrying the busiest queue chosen in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqs_rsp_if #(
   parameter int unsigned INDEX_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [INDEX_BITS-1:0] busiest_index;

   modport source (
      output valid, found, busiest_index,
      input  ready
   );

   modport sink (
      input  valid, found, busiest_index,
      output ready
   );
endinterface

`default_nettype wire

// File: src/bqs_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqs_csr_if
   import bqs_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// File: src/bqs_csr.sv
// ----------------------------------------------------------------------------
// Busiest queue select configuration registers
// Holds the selection policy registers written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bqs_csr
   import bqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bqs_csr_if.sink    csr_port,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    csr_xfer;

   assign csr_port.ready = 1'b1;
   assign csr_xfer       = csr_port.valid && csr_port.ready;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_xfer) begin
         case (csr_index_type'(csr_port.index))
            CSR_CLASS_LIMIT:     cfg_in.class_limit     = csr_port.data[CLASS_BITS-1:0];
            CSR_MISFIT_MODE:     cfg_in.misfit_mode     = csr_port.data[0];
            CSR_ASYM_CAPACITY:   cfg_in.asym_capacity   = csr_port.data[0];
            CSR_DEST_CAPACITY:   cfg_in.dest_capacity   = csr_port.data[CAP_BITS-1:0];
            CSR_IMBALANCE_LIMIT: cfg_in.imbalance_limit = csr_port.data[LIMIT_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.class_limit     <= CLASS_LIMIT_RESET;
         cfg_ff.misfit_mode     <= 1'b0;
         cfg_ff.asym_capacity   <= 1'b0;
         cfg_ff.dest_capacity   <= DEST_CAPACITY_RESET;
         cfg_ff.imbalance_limit <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/bqs_core.sv
// ----------------------------------------------------------------------------
// Busiest queue select core
// Input register, running best-queue state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "busiest_queue_select_unit_macros.svh"

module bqs_core
   import bqs_pkg::*;
#(
   parameter int unsigned INDEX_BITS = 8,
   parameter int unsigned LOAD_BITS  = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   bqs_req_if.sink     req_port,
   bqs_rsp_if.source   rsp_port
);

   localparam int unsigned LIM_W  = (LOAD_BITS > LIMIT_BITS) ? LOAD_BITS : LIMIT_BITS;
   localparam int unsigned PROD_W = LOAD_BITS + CAP_BITS;

   // Input register.
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [INDEX_BITS-1:0] s1_index_ff;
   logic [CLASS_BITS-1:0] s1_class_ff;
   logic [CAP_BITS-1:0]   s1_capacity_ff;
   logic [LOAD_BITS-1:0]  s1_load_ff;
   logic [COUNT_BITS-1:0] s1_count_ff;
   logic [LOAD_BITS-1:0]  s1_misfit_ff;
   logic                  s1_reduced_ff;
   logic                  s1_last_ff;

   // Running selection state.
   logic [LOAD_BITS-1:0]  best_load_ff;
   logic [LOAD_BITS-1:0]  best_load_in;
   logic [CAP_BITS-1:0]   best_capacity_ff;
   logic [CAP_BITS-1:0]   best_capacity_in;
   logic [INDEX_BITS-1:0] best_index_ff;
   logic [INDEX_BITS-1:0] best_index_in;
   logic                  have_best_ff;
   logic                  have_best_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  found_ff;
   logic                  found_in;
   logic [INDEX_BITS-1:0] busiest_index_ff;
   logic [INDEX_BITS-1:0] busiest_index_in;

   logic                  req_xfer;
   logic                  out_free;
   logic                  process;
   logic                  process_last;
   logic                  class_ok;
   logic                  lone_task;
   logic                  skip_asym;
   logic                  skip_lone;
   logic                  misfit_win;
   logic                  ratio_win;
   logic                  take;
   logic [PROD_W-1:0]     cand_product;
   logic [PROD_W-1:0]     best_product;

   assign req_xfer     = req_port.valid && req_port.ready;
   assign out_free     = !rsp_valid_ff || rsp_port.ready;
   assign process      = s1_valid_ff && (!s1_last_ff || out_free);
   assign process_last = process && s1_last_ff;

   assign req_port.ready         = !s1_valid_ff || process;
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.found         = found_ff;
   assign rsp_port.busiest_index = busiest_index_ff;

   always_comb begin
      class_ok     = s1_class_ff <= cfg.class_limit;
      lone_task    = s1_count_ff == LONE_TASK_COUNT;
      skip_asym    = cfg.asym_capacity && (cfg.dest_capacity < s1_capacity_ff) && lone_task;
      skip_lone    = lone_task && !s1_reduced_ff &&
                     (LIM_W'(s1_load_ff) > LIM_W'(cfg.imbalance_limit));
      misfit_win   = s1_misfit_ff > best_load_ff;
      cand_product = PROD_W'(s1_load_ff) * PROD_W'(best_capacity_ff);
      best_product = PROD_W'(best_load_ff) * PROD_W'(s1_capacity_ff);
      ratio_win    = cand_product > best_product;
      take         = class_ok &&
                     (cfg.misfit_mode ? misfit_win : (!skip_asym && !skip_lone && ratio_win));
   end

   always_comb begin
      s1_valid_in      = req_xfer || (s1_valid_ff && !process);
      best_load_in     = best_load_ff;
      best_capacity_in = best_capacity_ff;
      best_index_in    = best_index_ff;
      have_best_in     = have_best_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_port.ready;
      found_in         = found_ff;
      busiest_index_in = busiest_index_ff;

      if (process_last) begin
         best_load_in     = '0;
         best_capacity_in = BEST_CAPACITY_RESET;
         best_index_in    = '0;
         have_best_in     = 1'b0;
         rsp_valid_in     = 1'b1;
         found_in         = have_best_ff || take;
         busiest_index_in = take ? s1_index_ff : best_index_ff;
      end else if (process && take) begin
         best_load_in  = cfg.misfit_mode ? s1_misfit_ff : s1_load_ff;
         best_index_in = s1_index_ff;
         have_best_in  = 1'b1;
         if (!cfg.misfit_mode) begin
            best_capacity_in = s1_capacity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         best_load_ff     <= '0;
         best_capacity_ff <= BEST_CAPACITY_RESET;
         best_index_ff    <= '0;
         have_best_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         best_load_ff     <= best_load_in;
         best_capacity_ff <= best_capacity_in;
         best_index_ff    <= best_index_in;
         have_best_ff     <= have_best_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff         <= found_in;
      busiest_index_ff <= busiest_index_in;
      if (req_xfer) begin
         s1_index_ff    <= req_port.queue_index;
         s1_class_ff    <= req_port.queue_class;
         s1_capacity_ff <= req_port.queue_capacity;
         s1_load_ff     <= req_port.queue_load;
         s1_count_ff    <= req_port.running_count;
         s1_misfit_ff   <= req_port.misfit_load;
         s1_reduced_ff  <= req_port.capacity_reduced;
         s1_last_ff     <= req_port.last_queue;
      end
   end

   `BQS_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(process_last), "result appeared without a last queue")
   `BQS_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_port.ready) |-> !process_last, "pending result would be overwritten")
   `BQS_ASSERT(a_pass_cleared, clock, reset, process_last |=> (!have_best_ff && (best_load_ff == '0)), "selection state not cleared after a pass")
   `BQS_ASSERT(a_empty_state, clock, reset, !have_best_ff |-> ((best_load_ff == '0) && (best_capacity_ff == BEST_CAPACITY_RESET) && (best_index_ff == '0)), "empty selection holds stale state")

endmodule

`default_nettype wire

// File: src/busiest_queue_select_unit.sv
// ----------------------------------------------------------------------------
// Busiest queue select unit
// Streams run queue descriptors and reports the busiest queue of each pass.
//
// The feeder sends one descriptor per transfer on req_port and marks the
// final queue of a pass with last_queue. Only that final descriptor causes
// a transfer on rsp_port, which carries found and busiest_index.
// Policy registers are written over csr_port, which is always ready; the user
// must write them only while the unit is idle, as the block does not enforce it.
// A descriptor is captured in an input register and folded into the running
// best-queue state in the next cycle unless a held result stalls it, so one
// descriptor is taken every cycle while no stall holds the flow. The result of
// a pass is written to the result register when its last descriptor is folded.
// If the receiver stalls, the result is held and descriptors keep flowing
// until the next last descriptor reaches the input register, which then
// waits for the held result to be taken.
// Reset clears the pass state and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module busiest_queue_select_unit
   import bqs_pkg::*;
#(
   parameter int unsigned INDEX_BITS = 8,
   parameter int unsigned LOAD_BITS  = 32
)
(
   input  logic       clock,
   input  logic       reset,
   bqs_req_if.sink    req_port,
   bqs_rsp_if.source  rsp_port,
   bqs_csr_if.sink    csr_port
);

   cfg_type cfg;

   bqs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   bqs_core #(
      .INDEX_BITS (INDEX_BITS),
      .LOAD_BITS  (LOAD_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

// File: test/busiest_queue_select_unit_tb.sv
// ----------------------------------------------------------------------------
// Busiest queue select unit testbench
// Streams run queue descriptors into the unit under several policy settings
// and checks each reported selection against a predictor in the bench.
// Directed passes cover the field extremes, class skipping, zero capacity,
// lone-task skipping, ties and misfit mode. Random passes follow. Both
// channels idle at random, and once the receiver holds off long enough for
// the unit to stall its input.
// ----------------------------------------------------------------------------
module busiest_queue_select_unit_tb
   import bqs_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned INDEX_BITS       = 8;
   localparam int unsigned LOAD_BITS        = 32;
   localparam int          PERIOD           = 10;
   localparam int          IDLE_PERCENT     = 13;
   localparam int          QUIET_FROM       = 1200;
   localparam int          QUIET_TO         = 1900;
   localparam int          HOLD_AFTER_PICKS = 40;
   localparam int          HOLD_CYCLES      = 400;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          CYCLE_LIMIT      = 200000;
   localparam int          RANDOM_PHASES    = 9;
   localparam int          ITEMS_PER_PHASE  = 145;
   localparam int          MAX_REPORTS      = 50;

   typedef struct packed {
      logic [INDEX_BITS-1:0] queue_index;
      logic [CLASS_BITS-1:0] queue_class;
      logic [CAP_BITS-1:0]   queue_capacity;
      logic [LOAD_BITS-1:0]  queue_load;
      logic [COUNT_BITS-1:0] running_count;
      logic [LOAD_BITS-1:0]  misfit_load;
      logic                  capacity_reduced;
      logic                  last_queue;
   } queue_desc_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] busiest_index;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic           req_valid = 1'b0;
   queue_desc_type req_item  = '0;
   logic           rsp_ready = 1'b0;
   logic                      csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   bqs_req_if #(.INDEX_BITS(INDEX_BITS), .LOAD_BITS(LOAD_BITS)) req_bus ();
   bqs_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_bus ();
   bqs_csr_if csr_bus ();

   assign req_bus.valid            = req_valid;
   assign req_bus.queue_index      = req_item.queue_index;
   assign req_bus.queue_class      = req_item.queue_class;
   assign req_bus.queue_capacity   = req_item.queue_capacity;
   assign req_bus.queue_load       = req_item.queue_load;
   assign req_bus.running_count    = req_item.running_count;
   assign req_bus.misfit_load      = req_item.misfit_load;
   assign req_bus.capacity_reduced = req_item.capacity_reduced;
   assign req_bus.last_queue       = req_item.last_queue;
   assign rsp_bus.ready            = rsp_ready;
   assign csr_bus.valid            = csr_valid;
   assign csr_bus.index            = csr_index;
   assign csr_bus.data             = csr_data;

   busiest_queue_select_unit #(.INDEX_BITS(INDEX_BITS), .LOAD_BITS(LOAD_BITS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Policy registers and running selection as the unit should hold them.
   cfg_type unit_cfg = {CLASS_LIMIT_RESET, 1'b0, 1'b0, DEST_CAPACITY_RESET, 32'd0};
   logic [LOAD_BITS-1:0]  best_load     = '0;
   logic [CAP_BITS-1:0]   best_capacity = BEST_CAPACITY_RESET;
   logic [INDEX_BITS-1:0] best_index    = '0;
   logic                  have_best     = 1'b0;

   queue_desc_type pending_queues[$];
   pick_type       expected_picks[$];
   int req_offers  = 0;
   int req_accepts = 0;
   int picks_seen  = 0;
   int mismatches  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   logic hold_done = 1'b0;
   logic quiet;

   assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("busiest_queue_select_unit_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got,
                  want);
      mismatches++;
   endtask

   // Folds one descriptor into the selection and closes the pass on the last one.
   task automatic fold_descriptor(input queue_desc_type d);
      logic [63:0] new_ratio;
      logic [63:0] best_ratio;
      logic        lone;
      pick_type    pick;
      lone = (d.running_count == LONE_TASK_COUNT);
      if (d.queue_class <= unit_cfg.class_limit) begin
         if (unit_cfg.misfit_mode) begin
            if (d.misfit_load > best_load) begin
               best_load  = d.misfit_load;
               best_index = d.queue_index;
               have_best  = 1'b1;
            end
         end else if (!(unit_cfg.asym_capacity && lone &&
                        unit_cfg.dest_capacity < d.queue_capacity) &&
                      !(lone && d.queue_load > unit_cfg.imbalance_limit &&
                        !d.capacity_reduced)) begin
            new_ratio  = 64'(d.queue_load) * 64'(best_capacity);
            best_ratio = 64'(best_load) * 64'(d.queue_capacity);
            if (new_ratio > best_ratio) begin
               best_load     = d.queue_load;
               best_capacity = d.queue_capacity;
               best_index    = d.queue_index;
               have_best     = 1'b1;
            end
         end
      end
      if (d.last_queue) begin
         pick.found         = have_best;
         pick.busiest_index = have_best ? best_index : '0;
         expected_picks.push_back(pick);
         best_load     = '0;
         best_capacity = BEST_CAPACITY_RESET;
         best_index    = '0;
         have_best     = 1'b0;
      end
   endtask

   always @(negedge clock) begin : queue_driver
      logic busy;
      busy = req_valid && (req_offers != req_accepts);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!busy) begin
         if (pending_queues.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_item   <= pending_queues.pop_front();
            req_valid  <= 1'b1;
            req_offers <= req_offers + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!hold_done && picks_seen >= HOLD_AFTER_PICKS) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : pick_monitor
      pick_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_accepts <= req_accepts + 1;
            fold_descriptor(req_item);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            picks_seen <= picks_seen + 1;
            if (expected_picks.size() == 0) begin
               report_mismatch("unexpected result transfer, found", rsp_bus.found, 0);
            end else begin
               want = expected_picks.pop_front();
               if (rsp_bus.found !== want.found)
                  report_mismatch("found", rsp_bus.found, want.found);
               if (rsp_bus.busiest_index !== want.busiest_index)
                  report_mismatch("busiest_index", rsp_bus.busiest_index, want.busiest_index);
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_CLASS_LIMIT:     unit_cfg.class_limit     = data[CLASS_BITS-1:0];
         CSR_MISFIT_MODE:     unit_cfg.misfit_mode     = data[0];
         CSR_ASYM_CAPACITY:   unit_cfg.asym_capacity   = data[0];
         CSR_DEST_CAPACITY:   unit_cfg.dest_capacity   = data[CAP_BITS-1:0];
         CSR_IMBALANCE_LIMIT: unit_cfg.imbalance_limit = data[LIMIT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_policy(input logic [CLASS_BITS-1:0] class_limit, input logic misfit,
                               input logic asym, input logic [CAP_BITS-1:0] dest,
                               input logic [LIMIT_BITS-1:0] limit, input logic junk);
      logic [31:0] upper;
      upper = junk ? $urandom : 32'd0;
      write_register(CSR_CLASS_LIMIT, {upper[31:CLASS_BITS], class_limit});
      write_register(CSR_MISFIT_MODE, {upper[31:1], misfit});
      write_register(CSR_ASYM_CAPACITY, {upper[31:1], asym});
      write_register(CSR_DEST_CAPACITY, {upper[31:CAP_BITS], dest});
      write_register(CSR_IMBALANCE_LIMIT, limit);
   endtask

   task automatic wait_idle();
      while (pending_queues.size() != 0 || req_offers != req_accepts ||
             expected_picks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic add_queue(input logic [INDEX_BITS-1:0] index,
                            input logic [CLASS_BITS-1:0] qclass,
                            input logic [CAP_BITS-1:0] capacity,
                            input logic [LOAD_BITS-1:0] load,
                            input logic [COUNT_BITS-1:0] running,
                            input logic [LOAD_BITS-1:0] misfit,
                            input logic reduced, input logic last);
      pending_queues.push_back({index, qclass, capacity, load, running, misfit, reduced, last});
   endtask

   function automatic queue_desc_type random_descriptor(input logic last,
                                                        input logic [LOAD_BITS-1:0] limit);
      queue_desc_type d;
      d.queue_index = INDEX_BITS'($urandom);
      d.queue_class = ($urandom_range(9) == 0) ? 2'd3 : CLASS_BITS'($urandom_range(2));
      case ($urandom_range(5))
         0:       d.queue_capacity = '0;
         1:       d.queue_capacity = 11'd1024;
         2:       d.queue_capacity = CAP_BITS'($urandom);
         default: d.queue_capacity = CAP_BITS'($urandom_range(1, 1024));
      endcase
      case ($urandom_range(7))
         0:       d.queue_load = '0;
         1:       d.queue_load = '1;
         2:       d.queue_load = $urandom;
         3:       d.queue_load = limit + LOAD_BITS'($urandom_range(2)) - 1;
         default: d.queue_load = $urandom_range(4096);
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: d.running_count = LONE_TASK_COUNT;
         4:          d.running_count = '0;
         5:          d.running_count = '1;
         6:          d.running_count = COUNT_BITS'($urandom);
         default:    d.running_count = COUNT_BITS'($urandom_range(2, 8));
      endcase
      case ($urandom_range(5))
         0:       d.misfit_load = '0;
         1:       d.misfit_load = '1;
         2:       d.misfit_load = $urandom;
         default: d.misfit_load = $urandom_range(5000);
      endcase
      d.capacity_reduced = 1'($urandom_range(1));
      d.last_queue       = last;
      return d;
   endfunction

   initial begin
      int made;
      int span;
      logic [CAP_BITS-1:0]   dest;
      logic [LIMIT_BITS-1:0] limit;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset policy: zero capacity pins the pick, lone tasks and ties.
      add_queue(8'd0,   2'd0, 11'd0,    32'd0,        16'd0,     32'd0,        1'b0, 1'b1);
      add_queue(8'd255, 2'd2, 11'd1024, 32'hFFFFFFFF, 16'hFFFF,  32'hFFFFFFFF, 1'b1, 1'b0);
      add_queue(8'd0,   2'd3, 11'd1,    32'hFFFFFFFF, 16'd2,     32'd0,        1'b0, 1'b0);
      add_queue(8'd17,  2'd1, 11'd0,    32'd5,        16'd2,     32'd0,        1'b0, 1'b0);
      add_queue(8'd18,  2'd0, 11'd2047, 32'hFFFFFFFF, 16'd16,    32'd0,        1'b0, 1'b1);
      add_queue(8'd40,  2'd0, 11'd512,  32'd100,      16'd1,     32'd0,        1'b0, 1'b0);
      add_queue(8'd41,  2'd0, 11'd512,  32'd100,      16'd1,     32'd0,        1'b1, 1'b0);
      add_queue(8'd42,  2'd0, 11'd1024, 32'd200,      16'd3,     32'd0,        1'b0, 1'b0);
      add_queue(8'd43,  2'd0, 11'd256,  32'd60,       16'd2,     32'd0,        1'b0, 1'b1);
      wait_idle();

      write_register(CSR_MISFIT_MODE, 32'd1);
      write_register(CSR_CLASS_LIMIT, 32'd1);
      add_queue(8'd5,   2'd2, 11'd100,  32'd999,      16'd2,     32'd7,        1'b0, 1'b0);
      add_queue(8'd6,   2'd1, 11'd100,  32'd0,        16'd2,     32'd0,        1'b0, 1'b0);
      add_queue(8'd7,   2'd0, 11'd0,    32'd0,        16'd1,     32'd0,        1'b0, 1'b1);
      add_queue(8'd8,   2'd1, 11'd1024, 32'd1,        16'd1,     32'd300,      1'b0, 1'b0);
      add_queue(8'd9,   2'd0, 11'd1024, 32'd1,        16'd1,     32'd300,      1'b0, 1'b0);
      add_queue(8'd10,  2'd0, 11'd5,    32'd1,        16'd1,     32'd301,      1'b0, 1'b1);
      wait_idle();

      write_policy(2'd3, 1'b0, 1'b1, 11'd512, 32'd1000, 1'b0);
      add_queue(8'd20,  2'd3, 11'd1024, 32'd50,       16'd1,     32'd0,        1'b1, 1'b0);
      add_queue(8'd21,  2'd0, 11'd512,  32'd50,       16'd1,     32'd0,        1'b0, 1'b0);
      add_queue(8'd22,  2'd0, 11'd600,  32'd5000,     16'd2,     32'd0,        1'b0, 1'b0);
      add_queue(8'd23,  2'd0, 11'd1,    32'd1001,     16'd1,     32'd0,        1'b0, 1'b1);
      add_queue(8'd24,  2'd0, 11'd0,    32'd0,        16'd0,     32'd0,        1'b0, 1'b1);
      wait_idle();

      // Writes beyond the register list must leave the policy untouched.
      for (int i = CSR_IMBALANCE_LIMIT + 1; i < (1 << CSR_INDEX_BITS); i++)
         write_register(CSR_INDEX_BITS'(i), $urandom);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         if (p == 0) begin
            write_policy(2'd0, 1'b1, 1'b1, 11'd0, 32'hFFFFFFFF, 1'b1);
         end else if (p == 1) begin
            write_policy(2'd3, 1'b0, 1'b1, 11'd2047, 32'd0, 1'b1);
         end else begin
            case ($urandom_range(3))
               0:       dest = '0;
               1:       dest = 11'd1024;
               2:       dest = CAP_BITS'($urandom);
               default: dest = CAP_BITS'($urandom_range(1, 1024));
            endcase
            case ($urandom_range(3))
               0:       limit = '0;
               1:       limit = '1;
               2:       limit = $urandom;
               default: limit = $urandom_range(4096);
            endcase
            write_policy(CLASS_BITS'($urandom_range(3)), $urandom_range(9) < 3,
                         1'($urandom_range(1)), dest, limit, 1'($urandom_range(1)));
         end
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int k = 0; k < span; k++)
               pending_queues.push_back(random_descriptor(k == span - 1,
                                                          unit_cfg.imbalance_limit));
            made += span;
         end
      end
      wait_idle();

      if (mismatches == 0) begin
         $display("busiest_queue_select_unit_tb passed");
      end else begin
         $display("busiest_queue_select_unit_tb failed");
      end
      $finish;
   end

endmodule
